// ===== rtl/core/smc_pkg.sv =====
// Shared types and constants of the sector corridor minimum range block.
// Used by smc_head, smc_cell and sector_corridor_min_range_top; no dependencies.
`default_nettype none

package smc_pkg;

    // Default number of angular sectors
    localparam int SECTORS_DEF = 5;

    // Fixed-point fraction bits of the rotation arithmetic
    localparam int FRAC = 15;

    // Stored distance width and its special values
    localparam int DIST_W = 18;
    localparam logic signed [DIST_W-1:0] NO_OBSTACLE = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] RANGE_MIN   = {1'b1, {(DIST_W-1){1'b0}}};

    // Port widths
    localparam int COORD_W    = 17;
    localparam int TRIG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SECT_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COS_START  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_START  = 3'd7;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_OBSTACLE = 2'd1,
        ACT_FLOOR    = 2'd2,
        ACT_REPORT   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_SEND
    } state_t;

    // Control flags that travel with a point along the chain
    typedef struct packed {
        logic valid;
        logic clear;
        logic floor_cell;
        logic z_ok;
    } tok_t;

    // Settings every cell needs
    typedef struct packed {
        logic [12:0]        half_width;
        logic [15:0]        min_range;
        logic [TRIG_W-1:0]  cos_step;
        logic [TRIG_W-1:0]  sin_step;
    } cell_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sector_corridor_min_range_top.sv =====
// Top level of the sector corridor minimum range block.
// Depends on smc_pkg, smc_head and smc_cell.
//
// Usage:
//   Input channel (s_valid / s_ready) carries one request per accepted edge:
//   clear, obstacle point, floor-cell point or report. Points and clears run
//   down a chain of one head stage and SECTORS cells, one stage per cycle, so
//   the block takes one of them every cycle while no report holds the input.
//   Cell k rotates the point by one more step angle, registers it, and then
//   updates its own nearest range from the registered point.
//   A report holds the input (s_ready low) until the chain has drained, then
//   sends SECTORS results, one per cycle while the receiver keeps up, in sector
//   order on the m_ channel, with m_last_sector on the final one. A report
//   therefore occupies the input until its last result is loaded.
//   Results sit in an output register: a stalled receiver (m_ready low) holds
//   the current result and pauses the report, while the next point may still
//   be accepted once the last result of a report is loaded.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the
//   edge they are seen; write only while the block is idle.
//   Reset (aresetn low, synchronous) restores the default settings, sets
//   every sector to 131071 (no obstacle) and empties the chain.
`default_nettype none

module sector_corridor_min_range_top #(
    parameter int SECTORS = smc_pkg::SECTORS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // request channel
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic [1:0]                               s_action,
    input  wire logic signed [smc_pkg::COORD_W-1:0]       s_point_x,
    input  wire logic signed [smc_pkg::COORD_W-1:0]       s_point_y,
    input  wire logic signed [smc_pkg::COORD_W-1:0]       s_point_z,
    // result channel
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic [smc_pkg::SECT_IDX_W-1:0]                m_sector_index,
    output logic signed [smc_pkg::DIST_W-1:0]             m_nearest_range,
    output logic                                          m_last_sector,
    // configuration
    input  wire logic                                     cfg_wr_en,
    input  wire logic [smc_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [smc_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

    // Coordinate width: 34 bits after the start rotation, one more per step
    localparam int CW   = 34 + SECTORS;
    localparam int IDXW = (SECTORS > 1) ? $clog2(SECTORS) : 1;

    // Settings
    logic [12:0]                         half_width_reg;
    logic signed [13:0]                  z_low_reg, z_high_reg;
    logic [15:0]                         min_range_reg;
    logic signed [smc_pkg::TRIG_W-1:0]   cos_step_reg, sin_step_reg;
    logic signed [smc_pkg::TRIG_W-1:0]   cos_start_reg, sin_start_reg;

    // Control
    smc_pkg::state_t                     state_reg, state_next;
    logic [IDXW-1:0]                     cnt_reg, cnt_next;
    logic                                cnt_last;
    smc_pkg::action_t                    s_act;
    logic                                accept, in_take, rep_take, busy, out_free, load;

    // Output register
    logic                                m_valid_reg, m_valid_next;
    logic [smc_pkg::SECT_IDX_W-1:0]      m_index_reg;
    logic signed [smc_pkg::DIST_W-1:0]   m_range_reg;
    logic                                m_last_reg;

    // Chain
    smc_pkg::cell_cfg_t                  cell_cfg;
    smc_pkg::tok_t                       tok_chain [SECTORS+1];
    logic signed [CW-1:0]                x_chain   [SECTORS+1];
    logic signed [CW-1:0]                y_chain   [SECTORS+1];
    logic signed [smc_pkg::DIST_W-1:0]   dist_arr  [SECTORS];
    logic [SECTORS-1:0]                  cell_valid;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= 13'd100;
            z_low_reg      <= -14'sd1300;
            z_high_reg     <= 14'sd400;
            min_range_reg  <= 16'd1000;
            cos_step_reg   <= 16'sd32309;
            sin_step_reg   <= 16'sd5465;
            cos_start_reg  <= 16'sd28715;
            sin_start_reg  <= -16'sd15786;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                smc_pkg::REG_HALF_WIDTH: half_width_reg <= cfg_wdata[12:0];
                smc_pkg::REG_Z_LOW:      z_low_reg      <= $signed(cfg_wdata[13:0]);
                smc_pkg::REG_Z_HIGH:     z_high_reg     <= $signed(cfg_wdata[13:0]);
                smc_pkg::REG_MIN_RANGE:  min_range_reg  <= cfg_wdata;
                smc_pkg::REG_COS_STEP:   cos_step_reg   <= $signed(cfg_wdata);
                smc_pkg::REG_SIN_STEP:   sin_step_reg   <= $signed(cfg_wdata);
                smc_pkg::REG_COS_START:  cos_start_reg  <= $signed(cfg_wdata);
                smc_pkg::REG_SIN_START:  sin_start_reg  <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign cell_cfg = '{
        half_width: half_width_reg,
        min_range:  min_range_reg,
        cos_step:   cos_step_reg,
        sin_step:   sin_step_reg
    };

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign s_act    = smc_pkg::action_t'(s_action);
    assign accept   = s_valid && s_ready;
    assign in_take  = accept && (s_act != smc_pkg::ACT_REPORT);
    assign rep_take = accept && (s_act == smc_pkg::ACT_REPORT);

    // ------------------------------------------------------------------
    // Head and sector cells
    // ------------------------------------------------------------------
    smc_head #(
        .CW (CW)
    ) u_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (in_take),
        .action    (s_act),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .point_z   (s_point_z),
        .z_low     (z_low_reg),
        .z_high    (z_high_reg),
        .cos_start (cos_start_reg),
        .sin_start (sin_start_reg),
        .tok_o     (tok_chain[0]),
        .x_o       (x_chain[0]),
        .y_o       (y_chain[0])
    );

    for (genvar k = 0; k < SECTORS; k++) begin : g_cell
        smc_cell #(
            .CW (CW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cell_cfg),
            .tok_i   (tok_chain[k]),
            .x_i     (x_chain[k]),
            .y_i     (y_chain[k]),
            .tok_o   (tok_chain[k+1]),
            .x_o     (x_chain[k+1]),
            .y_o     (y_chain[k+1]),
            .dist_o  (dist_arr[k])
        );
        assign cell_valid[k] = tok_chain[k+1].valid;
    end

    // Chain holds a request until the last cell has written its range
    assign busy = tok_chain[0].valid || (|cell_valid);

    // ------------------------------------------------------------------
    // Report sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_last = (cnt_reg == IDXW'(SECTORS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smc_pkg::ST_RUN: begin
                if (rep_take) state_next = smc_pkg::ST_DRAIN;
            end
            smc_pkg::ST_DRAIN: begin
                if (!busy) state_next = smc_pkg::ST_SEND;
            end
            smc_pkg::ST_SEND: begin
                if (out_free && cnt_last) state_next = smc_pkg::ST_RUN;
            end
            default: state_next = smc_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        load    = 1'b0;
        unique case (state_reg)
            smc_pkg::ST_RUN:   s_ready = 1'b1;
            smc_pkg::ST_DRAIN: ;
            smc_pkg::ST_SEND:  load = out_free;
            default: ;
        endcase
    end

    // Advance the sector count per loaded result, wrap after the last
    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smc_pkg::ST_RUN;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled, reload when free
    // ------------------------------------------------------------------
    assign m_valid_next = load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_index_reg <= smc_pkg::SECT_IDX_W'(cnt_reg);
            m_range_reg <= dist_arr[cnt_reg];
            m_last_reg  <= cnt_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sector_index  = m_index_reg;
    assign m_nearest_range = m_range_reg;
    assign m_last_sector   = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Sector ranges must be settled while a report is sent
    a_send_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smc_pkg::ST_SEND) |-> !busy)
        else $error("chain busy while sending a report");

    // A waiting result that is not the last keeps the sequencer in the send state
    a_partial_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (state_reg == smc_pkg::ST_SEND))
        else $error("report left before its last sector");

    // Sector count stays within the sector range
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= IDXW'(SECTORS - 1))
        else $error("sector count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/smc_head.sv =====
// Head of the sector chain: swaps x and y, rotates by the start angle, checks height.
// Depends on smc_pkg.
`default_nettype none

module smc_head #(
    parameter int CW = 34 + smc_pkg::SECTORS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   in_take,
    input  wire smc_pkg::action_t                       action,
    input  wire logic signed [smc_pkg::COORD_W-1:0]     point_x,
    input  wire logic signed [smc_pkg::COORD_W-1:0]     point_y,
    input  wire logic signed [smc_pkg::COORD_W-1:0]     point_z,
    input  wire logic signed [13:0]                     z_low,
    input  wire logic signed [13:0]                     z_high,
    input  wire logic signed [smc_pkg::TRIG_W-1:0]      cos_start,
    input  wire logic signed [smc_pkg::TRIG_W-1:0]      sin_start,
    output smc_pkg::tok_t                               tok_o,
    output logic signed [CW-1:0]                        x_o,
    output logic signed [CW-1:0]                        y_o
);

    localparam int PW = smc_pkg::COORD_W + smc_pkg::TRIG_W;

    logic signed [PW-1:0] p_yc, p_xs, p_xc, p_ys;
    logic signed [PW:0]   sum_x, sum_y;
    logic                 floor_cell, z_ok;

    logic                 valid_reg;
    logic                 clear_reg, floor_reg, zok_reg;
    logic signed [CW-1:0] x_reg, y_reg;

    // Swapped point is already in Q.15 after one rotation, so no shift here
    always_comb begin
        p_yc  = point_y * cos_start;
        p_xs  = point_x * sin_start;
        p_xc  = point_x * cos_start;
        p_ys  = point_y * sin_start;
        sum_x = (PW+1)'(p_yc) + (PW+1)'(p_xs);
        sum_y = (PW+1)'(p_xc) - (PW+1)'(p_ys);
        floor_cell = (action == smc_pkg::ACT_FLOOR);
        z_ok = (point_z > z_low) && (point_z < z_high) && (!floor_cell || point_z[16]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            clear_reg <= (action == smc_pkg::ACT_CLEAR);
            floor_reg <= floor_cell;
            zok_reg   <= z_ok;
            x_reg     <= CW'(sum_x);
            y_reg     <= CW'(sum_y);
        end
    end

    assign tok_o = '{valid: valid_reg, clear: clear_reg, floor_cell: floor_reg, z_ok: zok_reg};
    assign x_o   = x_reg;
    assign y_o   = y_reg;

endmodule

`default_nettype wire

// ===== rtl/core/smc_cell.sv =====
// One sector cell: rotates the point by the step angle and keeps the nearest range.
// Depends on smc_pkg.
`default_nettype none

module smc_cell #(
    parameter int CW = 34 + smc_pkg::SECTORS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire smc_pkg::cell_cfg_t                   cfg,
    input  wire smc_pkg::tok_t                        tok_i,
    input  wire logic signed [CW-1:0]                 x_i,
    input  wire logic signed [CW-1:0]                 y_i,
    output smc_pkg::tok_t                             tok_o,
    output logic signed [CW-1:0]                      x_o,
    output logic signed [CW-1:0]                      y_o,
    output logic signed [smc_pkg::DIST_W-1:0]         dist_o
);

    localparam int PW = CW + smc_pkg::TRIG_W;

    logic signed [PW-1:0]  p_xc, p_ys, p_xs, p_yc;
    logic signed [PW:0]    sum_x, sum_y;
    logic signed [CW-1:0]  hw_q, mr_q, dist_q, d_sh;
    logic signed [smc_pkg::DIST_W-1:0] d_sat;
    logic                  lat_ok, range_ok, closer, hit;

    logic                  valid_reg;
    logic                  clear_reg, floor_reg, zok_reg;
    logic signed [CW-1:0]  x_reg, y_reg;
    logic signed [smc_pkg::DIST_W-1:0] dist_reg;

    // Step rotation, floored by the arithmetic shift
    always_comb begin
        p_xc  = x_i * $signed(cfg.cos_step);
        p_ys  = y_i * $signed(cfg.sin_step);
        p_xs  = x_i * $signed(cfg.sin_step);
        p_yc  = y_i * $signed(cfg.cos_step);
        sum_x = (PW+1)'(p_xc) + (PW+1)'(p_ys);
        sum_y = (PW+1)'(p_yc) - (PW+1)'(p_xs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= tok_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_i.valid) begin
            clear_reg <= tok_i.clear;
            floor_reg <= tok_i.floor_cell;
            zok_reg   <= tok_i.z_ok;
            x_reg     <= CW'(sum_x >>> smc_pkg::FRAC);
            y_reg     <= CW'(sum_y >>> smc_pkg::FRAC);
        end
    end

    // Corridor test on the rotated point, exact against the scaled bounds
    always_comb begin
        hw_q     = CW'(cfg.half_width) <<< smc_pkg::FRAC;
        mr_q     = CW'(cfg.min_range) <<< smc_pkg::FRAC;
        dist_q   = CW'(dist_reg) <<< smc_pkg::FRAC;
        lat_ok   = (y_reg > -hw_q) && (y_reg < hw_q);
        range_ok = !floor_reg || (x_reg >= mr_q);
        closer   = x_reg < dist_q;
        hit      = zok_reg && lat_ok && range_ok && closer;
        d_sh     = x_reg >>> smc_pkg::FRAC;
        if (d_sh < CW'(smc_pkg::RANGE_MIN)) begin
            d_sat = smc_pkg::RANGE_MIN;
        end else begin
            d_sat = smc_pkg::DIST_W'(d_sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= smc_pkg::NO_OBSTACLE;
        end else if (valid_reg) begin
            if (clear_reg) begin
                dist_reg <= smc_pkg::NO_OBSTACLE;
            end else if (hit) begin
                dist_reg <= d_sat;
            end
        end
    end

    assign tok_o  = '{valid: valid_reg, clear: clear_reg, floor_cell: floor_reg, z_ok: zok_reg};
    assign x_o    = x_reg;
    assign y_o    = y_reg;
    assign dist_o = dist_reg;

endmodule

`default_nettype wire
